FILE: rtl/fqsdr_pkg.sv
// Shared types and constants for the searchable FIFO queue block.
// No dependencies; the other files that use it refer to this package by scoped names.
package fqsdr_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int VALUE_W             = 32;

	// Operation codes carried in the opcode field of an input item
	typedef enum logic [2:0] {
		OP_ENQ    = 3'd0,
		OP_DEQ    = 3'd1,
		OP_SEARCH = 3'd2,
		OP_DELETE = 3'd3,
		OP_REV    = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Classified command handed from the front end to the execution engine
	typedef enum logic [2:0] {
		K_NOP,
		K_ENQ,
		K_DEQ,
		K_SEARCH,
		K_DELETE,
		K_REV,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	// Execution engine states
	typedef enum logic [3:0] {
		B_IDLE,
		B_WALK,
		B_REV_RLO,
		B_REV_RHI,
		B_REV_WLO,
		B_REV_WHI,
		B_FRONT,
		B_RESULT
	} back_state_t;

	typedef struct packed {
		logic [2:0]                opcode;
		logic signed [VALUE_W-1:0] operand_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                status;
		logic                      found;
		logic signed [VALUE_W-1:0] front_value;
		logic [4:0]                entry_count;
		logic [4:0]                removed_count;
	} out_item_t;

endpackage

FILE: rtl/fqsdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module fqsdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/fqsdr_front.sv
// Front end: accept input items, decode the opcode and hold commands in a
// two-entry queue for the execution engine. Uses fqsdr_pkg.
module fqsdr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fqsdr_pkg::in_item_t  in_data,
	output logic                 cmd_valid,
	output fqsdr_pkg::cmd_t      cmd,
	input  logic                 cmd_pop
);

	fqsdr_pkg::cmd_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	fqsdr_pkg::cmd_t dec;

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	// Classify the opcode; unused codes become a no-op
	always_comb begin
		dec.value = in_data.operand_value;
		unique case (in_data.opcode)
			fqsdr_pkg::OP_ENQ:    dec.kind = fqsdr_pkg::K_ENQ;
			fqsdr_pkg::OP_DEQ:    dec.kind = fqsdr_pkg::K_DEQ;
			fqsdr_pkg::OP_SEARCH: dec.kind = fqsdr_pkg::K_SEARCH;
			fqsdr_pkg::OP_DELETE: dec.kind = fqsdr_pkg::K_DELETE;
			fqsdr_pkg::OP_REV:    dec.kind = fqsdr_pkg::K_REV;
			fqsdr_pkg::OP_CLEAR:  dec.kind = fqsdr_pkg::K_CLEAR;
			default:              dec.kind = fqsdr_pkg::K_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

FILE: rtl/fqsdr_back.sv
// Execution engine: carry out queue commands against the entry RAM and
// register one result per command. Uses fqsdr_pkg and fqsdr_ram.
module fqsdr_back #(
	parameter int QUEUE_DEPTH = fqsdr_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  fqsdr_pkg::cmd_t      cmd,
	output logic                 cmd_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fqsdr_pkg::out_item_t out_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int VW = fqsdr_pkg::VALUE_W;

	fqsdr_pkg::back_state_t state_q, state_d;
	fqsdr_pkg::cmd_t        cmd_q;
	fqsdr_pkg::status_t     status_q;
	fqsdr_pkg::out_item_t   out_data_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] removed_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [VW-1:0] a_q;
	logic          pend_s1;
	logic          found_q;
	logic          out_valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;

	logic rd_go;
	logic match;
	logic full;
	logic out_free;
	logic rev_more;

	// Map a position from the head to a RAM address, wrapping once
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
			input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	fqsdr_ram #(
		.WIDTH(VW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_go    = (idx_q < count_q);
	assign match    = pend_s1 && (ram_rdata == cmd_q.value);
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign rev_more = ((CW+1)'(lo_q) + (CW+1)'(2)) < (CW+1)'(hi_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqsdr_pkg::B_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind) inside
						fqsdr_pkg::K_SEARCH, fqsdr_pkg::K_DELETE: state_d = fqsdr_pkg::B_WALK;
						fqsdr_pkg::K_REV: state_d = (count_q > CW'(1)) ?
							fqsdr_pkg::B_REV_RLO : fqsdr_pkg::B_FRONT;
						default: state_d = fqsdr_pkg::B_FRONT;
					endcase
				end
			end
			fqsdr_pkg::B_WALK: begin
				if (!rd_go && !pend_s1) begin
					state_d = fqsdr_pkg::B_FRONT;
				end
			end
			fqsdr_pkg::B_REV_RLO: state_d = fqsdr_pkg::B_REV_RHI;
			fqsdr_pkg::B_REV_RHI: state_d = fqsdr_pkg::B_REV_WLO;
			fqsdr_pkg::B_REV_WLO: state_d = fqsdr_pkg::B_REV_WHI;
			fqsdr_pkg::B_REV_WHI: state_d = rev_more ?
				fqsdr_pkg::B_REV_RLO : fqsdr_pkg::B_FRONT;
			fqsdr_pkg::B_FRONT: state_d = fqsdr_pkg::B_RESULT;
			fqsdr_pkg::B_RESULT: begin
				if (out_free) begin
					state_d = fqsdr_pkg::B_IDLE;
				end
			end
			default: state_d = fqsdr_pkg::B_IDLE;
		endcase
	end

	// RAM port and pop control
	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = slot(head_q, kept_q);
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		unique case (state_q)
			fqsdr_pkg::B_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && (cmd.kind == fqsdr_pkg::K_ENQ) && !full) begin
					ram_we    = 1'b1;
					ram_waddr = slot(head_q, count_q);
					ram_wdata = cmd.value;
				end
			end
			fqsdr_pkg::B_WALK: begin
				ram_re    = rd_go;
				ram_raddr = slot(head_q, idx_q);
				ram_we    = pend_s1 && (cmd_q.kind == fqsdr_pkg::K_DELETE) && !match;
			end
			fqsdr_pkg::B_REV_RLO: begin
				ram_re    = 1'b1;
				ram_raddr = slot(head_q, lo_q);
			end
			fqsdr_pkg::B_REV_RHI: begin
				ram_re    = 1'b1;
				ram_raddr = slot(head_q, hi_q);
			end
			fqsdr_pkg::B_REV_WLO: begin
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, lo_q);
			end
			fqsdr_pkg::B_REV_WHI: begin
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, hi_q);
				ram_wdata = a_q;
			end
			fqsdr_pkg::B_FRONT: begin
				ram_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fqsdr_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_q     <= cmd;
					found_q   <= 1'b0;
					removed_q <= '0;
					idx_q     <= '0;
					kept_q    <= '0;
					pend_s1   <= 1'b0;
					lo_q      <= '0;
					hi_q      <= count_q - CW'(1);
				end
			end
			fqsdr_pkg::B_WALK: begin
				pend_s1 <= rd_go;
				if (rd_go) begin
					idx_q <= idx_q + CW'(1);
				end
				if (match) begin
					found_q <= 1'b1;
				end
				if (pend_s1 && !match) begin
					kept_q <= kept_q + CW'(1);
				end
				if (!rd_go && !pend_s1 && (cmd_q.kind == fqsdr_pkg::K_DELETE)) begin
					removed_q <= count_q - kept_q;
				end
			end
			fqsdr_pkg::B_REV_RHI: a_q <= ram_rdata;
			fqsdr_pkg::B_REV_WHI: begin
				lo_q <= lo_q + CW'(1);
				hi_q <= hi_q - CW'(1);
			end
			default: begin
			end
		endcase
		if ((state_q == fqsdr_pkg::B_RESULT) && out_free) begin
			out_data_q.status        <= status_q;
			out_data_q.found         <= found_q && (cmd_q.kind == fqsdr_pkg::K_SEARCH);
			out_data_q.front_value   <= (count_q != '0) ? ram_rdata : '0;
			out_data_q.entry_count   <= 5'(count_q);
			out_data_q.removed_count <= 5'(removed_q);
		end
	end

	// Control registers: state, queue pointers, status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqsdr_pkg::B_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			status_q    <= fqsdr_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == fqsdr_pkg::B_IDLE) && cmd_valid) begin
				status_q <= fqsdr_pkg::ST_OK;
				case (cmd.kind)
					fqsdr_pkg::K_ENQ: begin
						if (full) begin
							status_q <= fqsdr_pkg::ST_FULL;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					fqsdr_pkg::K_DEQ: begin
						if (count_q == '0) begin
							status_q <= fqsdr_pkg::ST_EMPTY;
						end else begin
							head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
							count_q <= count_q - CW'(1);
						end
					end
					fqsdr_pkg::K_CLEAR: begin
						head_q  <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if ((state_q == fqsdr_pkg::B_WALK) && !rd_go && !pend_s1 &&
					(cmd_q.kind == fqsdr_pkg::K_DELETE)) begin
				count_q <= kept_q;
			end
			if ((state_q == fqsdr_pkg::B_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/fifo_queue_with_search_delete_reverse.sv
// Top level of the bounded FIFO queue with search, delete-all-equal and reverse.
// Uses fqsdr_pkg, fqsdr_front and fqsdr_back (which holds fqsdr_ram).
//
// in channel  (in_valid / in_ready / in_data): one item per operation, opcode
//   plus operand_value. Every accepted item gives exactly one result.
// out channel (out_valid / out_ready / out_data): status, found flag, head
//   entry, entry count and removed count, in the order items were accepted.
// The front end decodes items into a two-entry command queue; the back end
// executes one command at a time against a registered-read entry RAM and
// loads an output register.
// Engine steps per item, with N the entry count when the command starts:
//   enqueue, dequeue, clear, no-op: decode in idle, head read, result.
//   search, delete: one RAM read per entry walked, then head read and result.
//   reverse: floor(N/2) swapped pairs, each read low, read high, write low,
//     write high (one read and one write port), then head read and result.
// Reset clears head, count and all handshake state; the entry RAM is not
// cleared since only entries within the count are ever used. When out_ready
// is low the result holds in the output register and the engine waits with
// its next result; the front still takes items until its queue is full.
module fifo_queue_with_search_delete_reverse #(
	parameter int QUEUE_DEPTH = fqsdr_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fqsdr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fqsdr_pkg::out_item_t out_data
);

	// Decoded command between front and back
	logic            cmd_valid;
	logic            cmd_pop;
	fqsdr_pkg::cmd_t cmd;

	fqsdr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	fqsdr_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: rtl/fqsdr_checker.sv
// Port-level checks for the searchable FIFO queue, bound to the top level.
// Uses fqsdr_pkg.
module fqsdr_checker #(
	parameter int QUEUE_DEPTH = fqsdr_pkg::DEFAULT_QUEUE_DEPTH
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input fqsdr_pkg::out_item_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Drop an enqueue only when the queue is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == fqsdr_pkg::ST_FULL)
		|-> out_data.entry_count == 5'(QUEUE_DEPTH))
		else $error("full status with queue not full");

	// Empty dequeue leaves an empty queue reporting zero at the head
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == fqsdr_pkg::ST_EMPTY)
		|-> (out_data.entry_count == 5'd0) && (out_data.front_value == '0))
		else $error("empty status with entries held");

	// Search and delete outcomes never coexist with each other or a fault
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.removed_count != 5'd0)
		|-> !out_data.found && (out_data.status == fqsdr_pkg::ST_OK))
		else $error("removed count with found flag or error status");

	// Count never exceeds the capacity (checked for capacities up to 31)
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (QUEUE_DEPTH > 31) || (out_data.entry_count <= 5'(QUEUE_DEPTH)))
		else $error("entry count beyond capacity");

endmodule

bind fifo_queue_with_search_delete_reverse fqsdr_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_fqsdr_checker (.*);
